// ===== hw/rtl/oli_pkg.sv =====
// ----------------------------------------------------------------------------
// oli_pkg
// Shared types for the ordered list engine: operation and status codes,
// request and response payloads, controller states and datapath commands.
// ----------------------------------------------------------------------------
package oli_pkg;

  // operation codes
  typedef enum logic [2:0] {
    FN_APPEND    = 3'd0,
    FN_INSERT_AT = 3'd1,
    FN_POP_FIRST = 3'd2,
    FN_POP_LAST  = 3'd3,
    FN_POP_AT    = 3'd4,
    FN_FIND      = 3'd5,
    FN_READ_AT   = 3'd6,
    FN_CLEAR     = 3'd7
  } func_e;

  // response status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // request payload
  typedef struct packed {
    func_e              func;
    logic signed [31:0] value;
    logic        [3:0]  index;
  } req_t;

  // response payload
  typedef struct packed {
    status_e            status;
    logic signed [31:0] result_value;
    logic        [2:0]  position;
    logic        [3:0]  fill_count;
  } rsp_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_FIND = 2'd2,
    S_RESP = 2'd3
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic resolve;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/oli_ctrl.sv =====
// ----------------------------------------------------------------------------
// oli_ctrl
// Sequencer for the list engine: takes a request, runs the update step,
// then the find resolve step, then presents the response for one cycle.
// ----------------------------------------------------------------------------
module oli_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             rsp_valid_o,
  output oli_pkg::dp_cmd_t cmd_o
);

  oli_pkg::state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oli_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and command decode
  always_comb begin
    state_d       = state_q;
    busy          = 1'b0;
    rsp_valid_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.exec    = 1'b0;
    cmd_o.resolve = 1'b0;
    case (state_q)
      oli_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = oli_pkg::S_EXEC;
        end
      end
      oli_pkg::S_EXEC: begin
        busy       = 1'b1;
        cmd_o.exec = 1'b1;
        state_d    = oli_pkg::S_FIND;
      end
      oli_pkg::S_FIND: begin
        busy          = 1'b1;
        cmd_o.resolve = 1'b1;
        state_d       = oli_pkg::S_RESP;
      end
      oli_pkg::S_RESP: begin
        // response registers stay put until the next update step
        rsp_valid_o = 1'b1;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = oli_pkg::S_EXEC;
        end else begin
          state_d = oli_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = oli_pkg::S_IDLE;
      end
    endcase
  end

  // sequencing checks
  a_exec_then_resolve : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> cmd_o.resolve)
    else $error("update step not followed by resolve step");

  a_valid_after_resolve : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.resolve |=> rsp_valid_o)
    else $error("resolve step not followed by response");

endmodule

// ===== hw/rtl/oli_datapath.sv =====
// ----------------------------------------------------------------------------
// oli_datapath
// Slot cells, count register and response registers. Every cell shifts,
// loads or compares in parallel under the commands of the sequencer.
// ----------------------------------------------------------------------------
module oli_datapath #(
  parameter int CAPACITY = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  oli_pkg::dp_cmd_t cmd_i,
  input  oli_pkg::req_t    req_i,
  output oli_pkg::rsp_t    rsp_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = ((CW > 4) ? CW : 4) + 1;
  localparam logic [AW-1:0] CapA = AW'(CAPACITY);

  oli_pkg::req_t           req_q;
  logic signed [31:0]      slots_q [CAPACITY];
  logic signed [31:0]      slots_d [CAPACITY];
  logic [CW-1:0]           occ_q, occ_d;
  logic [CAPACITY-1:0]     match_q, match_d;
  oli_pkg::status_e        status_q, status_d;
  logic signed [31:0]      rv_q;
  logic [2:0]              pos_q;

  logic [AW-1:0]           occ_a, idx_a, pos_a;
  logic                    full, empty;
  logic                    do_ins, do_rem, do_clr, take;
  logic signed [31:0]      sel_val;
  logic [CAPACITY-1:0]     lowest;
  logic [2:0]              enc_pos;

  assign occ_a = AW'(occ_q);
  assign idx_a = AW'(req_q.index);
  assign full  = (occ_a >= CapA);
  assign empty = (occ_q == '0);

  // operation decode
  always_comb begin
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_clr   = 1'b0;
    take     = 1'b0;
    pos_a    = '0;
    status_d = oli_pkg::ST_OK;
    case (req_q.func)
      oli_pkg::FN_APPEND: begin
        if (full) begin
          status_d = oli_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          pos_a  = occ_a;
        end
      end
      oli_pkg::FN_INSERT_AT: begin
        if (idx_a > CapA) begin
          status_d = oli_pkg::ST_BADIDX;
        end else if (full) begin
          status_d = oli_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          pos_a  = (idx_a < occ_a) ? idx_a : occ_a;
        end
      end
      oli_pkg::FN_POP_FIRST: begin
        if (empty) begin
          status_d = oli_pkg::ST_EMPTY;
        end else begin
          do_rem = 1'b1;
          take   = 1'b1;
        end
      end
      oli_pkg::FN_POP_LAST: begin
        if (empty) begin
          status_d = oli_pkg::ST_EMPTY;
        end else begin
          do_rem = 1'b1;
          take   = 1'b1;
          pos_a  = occ_a - AW'(1);
        end
      end
      oli_pkg::FN_POP_AT: begin
        if (empty) begin
          status_d = oli_pkg::ST_EMPTY;
        end else if (idx_a >= CapA) begin
          status_d = oli_pkg::ST_BADIDX;
        end else if (idx_a < occ_a) begin
          do_rem = 1'b1;
          take   = 1'b1;
          pos_a  = idx_a;
        end
      end
      oli_pkg::FN_FIND: begin
        // settled in the resolve step
        status_d = oli_pkg::ST_NOTFOUND;
      end
      oli_pkg::FN_READ_AT: begin
        if (idx_a >= CapA) begin
          status_d = oli_pkg::ST_BADIDX;
        end else if (idx_a < occ_a) begin
          take  = 1'b1;
          pos_a = idx_a;
        end
      end
      oli_pkg::FN_CLEAR: begin
        do_clr = 1'b1;
      end
      default: begin
        status_d = oli_pkg::ST_OK;
      end
    endcase
  end

  // element select at the operation position
  always_comb begin
    sel_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (AW'(i) == pos_a) begin
        sel_val = sel_val | slots_q[i];
      end
    end
  end

  // per-cell next value and match
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_comb begin
      slots_d[g] = slots_q[g];
      if (do_clr) begin
        slots_d[g] = '0;
      end else if (do_ins) begin
        if (AW'(g) == pos_a) begin
          slots_d[g] = req_q.value;
        end else if (AW'(g) > pos_a) begin
          if (g > 0) begin
            slots_d[g] = slots_q[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (do_rem) begin
        if (AW'(g) >= pos_a) begin
          if (g < CAPACITY - 1) begin
            slots_d[g] = slots_q[(g < CAPACITY - 1) ? g + 1 : g];
          end else begin
            slots_d[g] = '0;
          end
        end
      end
    end
    assign match_d[g] = (AW'(g) < occ_a) && (slots_q[g] == req_q.value);
  end

  // count update
  always_comb begin
    occ_d = occ_q;
    if (do_clr) begin
      occ_d = '0;
    end else if (do_ins) begin
      occ_d = occ_q + CW'(1);
    end else if (do_rem) begin
      occ_d = occ_q - CW'(1);
    end
  end

  // first match: isolate lowest set bit, then encode
  assign lowest = match_q & (~match_q + {{(CAPACITY-1){1'b0}}, 1'b1});
  always_comb begin
    enc_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (lowest[i]) begin
        enc_pos = enc_pos | 3'(i);
      end
    end
  end

  // list state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        slots_q[i] <= '0;
      end
    end else if (cmd_i.exec) begin
      occ_q <= occ_d;
      for (int i = 0; i < CAPACITY; i++) begin
        slots_q[i] <= slots_d[i];
      end
    end
  end

  // request and response registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      rv_q     <= take ? sel_val : '0;
      pos_q    <= '0;
      match_q  <= match_d;
    end else if (cmd_i.resolve) begin
      if ((req_q.func == oli_pkg::FN_FIND) && (|match_q)) begin
        status_q <= oli_pkg::ST_OK;
        pos_q    <= enc_pos;
      end
    end
  end

  assign rsp_o.status       = status_q;
  assign rsp_o.result_value = rv_q;
  assign rsp_o.position     = pos_q;
  assign rsp_o.fill_count   = 4'(occ_q);

  // list state checks
  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    AW'(occ_q) <= CapA)
    else $error("count above capacity");

  a_occ_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (req_q.func != oli_pkg::FN_CLEAR) |=>
      (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + CW'(1)) ||
      (occ_q == $past(occ_q) - CW'(1)))
    else $error("count moved by more than one");

  for (genvar g = 0; g < CAPACITY; g++) begin : g_chk
    a_free_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (AW'(g) >= AW'(occ_q)) |-> (slots_q[g] == '0))
      else $error("free slot not zero");
  end

endmodule

// ===== hw/rtl/ordered_list_insert_delete_top.sv =====
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_top
// A transferred request passes the update step, then the find resolve step,
// then the response cycle, in which its response is strobed. A new request
// is not taken while busy; start is taken again during the response cycle.
// The pace is set by the sequencer's update and resolve steps.
// Reset clears all slots and the count at once; the receiver cannot stall.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_top #(
  parameter int CAPACITY = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  oli_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output oli_pkg::rsp_t rsp_o
);

  oli_pkg::dp_cmd_t cmd;

  // sequencer
  oli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .rsp_valid_o (rsp_valid_o),
    .cmd_o       (cmd)
  );

  // slot cells and response registers
  oli_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
